>>> hw/rtl/multi_pool_index_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pool index allocator
// Clocked, reset-qualified wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MULTI_POOL_INDEX_ALLOCATOR_ASSERT_SVH
`define MULTI_POOL_INDEX_ALLOCATOR_ASSERT_SVH

// property must hold at every clock edge outside reset
`define MPIA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define MPIA_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

>>> hw/rtl/mpia_pkg.sv
// ----------------------------------------------------------------------------
// mpia_pkg
// Sizes, codes, request type and helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
package mpia_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int NUM_POOLS = 16;

    localparam int OP_W   = 2;
    localparam int POOL_W = 4;
    localparam int SLOT_W = 10;
    localparam int STAT_W = 2;

    localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int PIX_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int ADDR_W    = PIX_W + IDX_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_QUERY
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              pool_ok;
        logic              slot_ok;
        logic [PIX_W-1:0]  pix;
        logic [IDX_W-1:0]  sidx;
        logic [SLOT_W-1:0] slot;
    } req_t;

    function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, s};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] i);
        logic [SLOT_W+IDX_W-1:0] w;
        w = {{SLOT_W{1'b0}}, i};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] pool_to_pix(input logic [POOL_W-1:0] p);
        logic [POOL_W+PIX_W-1:0] w;
        w = {{PIX_W{1'b0}}, p};
        return w[PIX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(POOL_SIZE - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

>>> hw/rtl/mpia_front.sv
// ----------------------------------------------------------------------------
// mpia_front
// Accepts request beats, decodes and range-checks them, and queues them
// for the back end.
// ----------------------------------------------------------------------------
module mpia_front import mpia_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [POOL_W-1:0] s_pool,
    input  logic [SLOT_W-1:0] s_slot,
    input  logic              init_done,
    output logic              q_valid,
    input  logic              q_ready,
    output req_t              q_req
);

    req_t               cls;
    req_t               q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               push, pop;

    always_comb begin
        unique case (s_operation)
            OP_ALLOC: cls.kind = K_ALLOC;
            OP_FREE:  cls.kind = K_FREE;
            default:  cls.kind = K_QUERY;
        endcase
        cls.pool_ok = (32'(s_pool) < NUM_POOLS);
        cls.slot_ok = (32'(s_slot) < POOL_SIZE);
        cls.pix     = pool_to_pix(s_pool);
        cls.sidx    = slot_to_idx(s_slot);
        cls.slot    = s_slot;
    end

    assign s_ready = init_done && (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_req   = q_mem[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= cls;
        end
    end

endmodule

>>> hw/rtl/mpia_back.sv
// ----------------------------------------------------------------------------
// mpia_back
// Carries out queued requests against the free rings and in-use flags,
// one at a time, and holds the result beat.
// ----------------------------------------------------------------------------
module mpia_back import mpia_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  req_t              q_req,
    output logic              init_done,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [SLOT_W-1:0] m_slot_out
);

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg;

    logic [IDX_W-1:0]    ring_mem [MEM_DEPTH];
    logic                flag_mem [MEM_DEPTH];

    logic [IDX_W-1:0]    rd_ptr_reg   [NUM_POOLS];
    logic [IDX_W-1:0]    wr_ptr_reg   [NUM_POOLS];
    logic [CNT_W-1:0]    free_cnt_reg [NUM_POOLS];
    logic                wrap_reg     [NUM_POOLS];

    req_t                req_reg;
    logic [IDX_W-1:0]    rp_reg, wp_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                ring_wr_reg;
    logic [IDX_W-1:0]    ring_q_reg;
    logic                flag_q_reg;

    logic                m_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [SLOT_W-1:0]   slot_out_reg;

    logic                take, fire;
    logic [IDX_W-1:0]    alloc_idx;
    logic [STAT_W-1:0]   st;
    logic [SLOT_W-1:0]   so;
    logic                do_pop, do_push, flag_we, flag_wd;
    logic [ADDR_W-1:0]   flag_wa;

    assign init_done  = (state_reg != S_INIT);
    assign q_ready    = (state_reg == S_IDLE);
    assign take       = q_valid && q_ready;
    assign fire       = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_slot_out = slot_out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INIT) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // latch the request and its pool's pointers; start the memory reads
    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg     <= q_req;
            rp_reg      <= rd_ptr_reg[q_req.pix];
            wp_reg      <= wr_ptr_reg[q_req.pix];
            cnt_reg     <= free_cnt_reg[q_req.pix];
            ring_wr_reg <= wrap_reg[q_req.pix] ||
                           (rd_ptr_reg[q_req.pix] < wr_ptr_reg[q_req.pix]);
            ring_q_reg  <= ring_mem[{q_req.pix, rd_ptr_reg[q_req.pix]}];
            flag_q_reg  <= flag_mem[{q_req.pix, q_req.sidx}];
        end
    end

    // unwritten ring positions still hold their reset index
    assign alloc_idx = ring_wr_reg ? ring_q_reg : rp_reg;

    always_comb begin
        st      = ST_OK;
        so      = req_reg.slot;
        do_pop  = 1'b0;
        do_push = 1'b0;
        flag_we = 1'b0;
        flag_wd = 1'b0;
        flag_wa = {req_reg.pix, req_reg.sidx};
        unique case (req_reg.kind)
            K_ALLOC: begin
                if (!req_reg.pool_ok || (cnt_reg == '0)) begin
                    st = ST_EMPTY;
                    so = '0;
                end else begin
                    do_pop  = 1'b1;
                    flag_we = 1'b1;
                    flag_wd = 1'b1;
                    flag_wa = {req_reg.pix, alloc_idx};
                    so      = idx_to_slot(alloc_idx);
                end
            end
            K_FREE: begin
                if (!req_reg.pool_ok || !req_reg.slot_ok || !flag_q_reg) begin
                    st = ST_NOT_USED;
                end else begin
                    flag_we = 1'b1;
                    // full ring: flag cleared, push dropped
                    do_push = (cnt_reg < CNT_W'(POOL_SIZE));
                end
            end
            default: begin
                if (!req_reg.pool_ok || !req_reg.slot_ok || !flag_q_reg) begin
                    st = ST_NOT_USED;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_INIT) begin
            flag_mem[clr_addr_reg] <= 1'b0;
        end else if (fire && flag_we) begin
            flag_mem[flag_wa] <= flag_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && do_push) begin
            ring_mem[{req_reg.pix, wp_reg}] <= req_reg.sidx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_POOLS; i++) begin
                rd_ptr_reg[i]   <= '0;
                wr_ptr_reg[i]   <= '0;
                free_cnt_reg[i] <= CNT_W'(POOL_SIZE);
                wrap_reg[i]     <= 1'b0;
            end
        end else if (fire) begin
            if (do_pop) begin
                rd_ptr_reg[req_reg.pix]   <= next_pos(rp_reg);
                free_cnt_reg[req_reg.pix] <= cnt_reg - 1'b1;
            end
            if (do_push) begin
                wr_ptr_reg[req_reg.pix]   <= next_pos(wp_reg);
                free_cnt_reg[req_reg.pix] <= cnt_reg + 1'b1;
                if (wp_reg == IDX_W'(POOL_SIZE - 1)) begin
                    wrap_reg[req_reg.pix] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg   <= st;
            slot_out_reg <= so;
        end
    end

endmodule

>>> hw/rtl/multi_pool_index_allocator.sv
// ----------------------------------------------------------------------------
// multi_pool_index_allocator
// Slot-index allocator over several pools, each with a FIFO ring of free
// indices and an in-use flag per slot.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one result beat, in order. The back end
// takes a request only when idle: first the registered reads of the free
// ring and flag memories, then the update and result; this read-modify-write
// on the shared memories means it takes no new request before the last
// one's result is registered. A two-entry queue between front and back end,
// and the result register, let requests be taken while a result waits. After
// reset the in-use flags are cleared, one entry per cycle over all 16384
// entries, during which s_ready stays low.
module multi_pool_index_allocator import mpia_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [POOL_W-1:0] s_pool,
    input  logic [SLOT_W-1:0] s_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [SLOT_W-1:0] m_slot_out
);

    logic q_valid;
    logic q_ready;
    req_t q_req;
    logic init_done;

    mpia_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_pool      (s_pool),
        .s_slot      (s_slot),
        .init_done   (init_done),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_req       (q_req)
    );

    mpia_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .init_done  (init_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot_out (m_slot_out)
    );

endmodule

>>> hw/rtl/mpia_checker.sv
// ----------------------------------------------------------------------------
// mpia_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_pool_index_allocator_assert.svh"

module mpia_checker import mpia_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [OP_W-1:0]   s_operation,
    input logic [POOL_W-1:0] s_pool,
    input logic [SLOT_W-1:0] s_slot,
    input logic              m_valid,
    input logic              m_ready,
    input logic [STAT_W-1:0] m_status,
    input logic [SLOT_W-1:0] m_slot_out
);

    // beats taken in but not yet delivered
    logic [2:0] pending_reg;
    logic       in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_beat && !out_beat) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (out_beat && !in_beat) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `MPIA_ASSERT(a_in_hold, aclk, aresetn,
        s_valid && !s_ready |=> s_valid && $stable(s_operation) && $stable(s_pool)
            && $stable(s_slot),
        "request beat changed while stalled")
    `MPIA_ASSERT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_out),
        "result beat changed while stalled")
    `MPIA_NEVER(a_no_spurious, aclk, aresetn, m_valid && (pending_reg == 3'd0),
        "result beat without an outstanding request")
    `MPIA_NEVER(a_bound, aclk, aresetn, pending_reg > 3'd4,
        "more requests in flight than the design can hold")
    `MPIA_ASSERT(a_empty_zero, aclk, aresetn,
        m_valid && (m_status == ST_EMPTY) |-> (m_slot_out == '0),
        "empty-pool result carries a non-zero index")

endmodule

bind multi_pool_index_allocator mpia_checker u_mpia_checker (.*);
